[rtl/tkbd_pkg.sv]
// Shared types and constants for the touch key baseline detector.
// No dependencies; tkbd_pipe, tkbd_ofifo and the core in rtl/ refer to it by scoped names.
package tkbd_pkg;

	// request opcodes
	localparam logic [1:0] OP_MEAS = 2'd0;
	localparam logic [1:0] OP_CLR  = 2'd1;
	localparam logic [1:0] OP_CAL  = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_COUNT = 2'd0;
	localparam logic [1:0] CFG_DEBOUNCE  = 2'd1;
	localparam logic [1:0] CFG_STROBE    = 2'd2;

	// running total holds AVG_DEPTH samples; depth is a power of two
	localparam int AVG_LOG2  = 4;
	localparam int AVG_DEPTH = 1 << AVG_LOG2;

	// x / 10 == (x * 52429) >> 19, exact for every 16-bit x
	localparam logic [16:0] DIV10_MUL   = 17'd52429;
	localparam int          DIV10_SHIFT = 19;

	// result queue
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

	typedef struct packed {
		logic [31:0] running_total;
		logic [15:0] mean;
		logic [15:0] low;
		logic [15:0] high;
		logic        pressed;
		logic        changed;
		logic [31:0] last_change;
		logic [31:0] strobe_start;
		logic [15:0] cal_max;
	} entry_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  key;
		logic [15:0] raw_count;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]  key_out;
		logic        pressed;
		logic        changed;
		logic [15:0] baseline;
		logic        ignored;
	} result_t;

	typedef struct packed {
		logic [3:0]  key_count;
		logic [15:0] debounce_ms;
		logic [15:0] strobe_ms;
	} cfg_t;

	typedef struct packed {
		logic       hold;
		logic [2:0] inflight;
	} pipe_stat_t;

endpackage

[rtl/tkbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tkbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/tkbd_pipe.sv]
// Per-key read-modify-write pipeline: state RAM, baseline tracking, thresholds
// and hysteresis. Depends on tkbd_pkg and tkbd_ram.
module tkbd_pipe #(
	parameter int KEYS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  tkbd_pkg::item_t      item,
	input  tkbd_pkg::cfg_t       cfg,
	output tkbd_pkg::pipe_stat_t stat,
	output logic                 res_valid,
	output tkbd_pkg::result_t    res
);

	localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int EW = $bits(tkbd_pkg::entry_t);

	logic [KW-1:0] in_idx;
	logic          in_ok;

	logic [EW-1:0]      rd_data;
	tkbd_pkg::entry_t   rd_e;
	tkbd_pkg::entry_t   e1;
	logic               wr_en;
	tkbd_pkg::entry_t   e_new;

	logic [KEYS-1:0] ent_q;
	logic [KEYS-1:0] cal_q;

	// stage 1: RAM data arrives
	logic             v_s1;
	tkbd_pkg::item_t  it_s1;
	logic [KW-1:0]    idx_s1;
	logic             ok_s1;
	logic [31:0]      dt_dbn;
	logic [31:0]      dt_str;
	logic [16:0]      thr;
	logic [15:0]      calmax;

	// stage 2: window compares and total update
	logic             v_s2;
	tkbd_pkg::item_t  it_s2;
	logic [KW-1:0]    idx_s2;
	logic             ok_s2;
	tkbd_pkg::entry_t e_s2;
	logic [31:0]      dt_dbn_s2;
	logic [31:0]      dt_str_s2;
	logic [16:0]      thr_s2;
	logic [15:0]      calmax_s2;
	logic             frozen;
	logic             str_ok;
	logic             upd;
	logic             meas;
	logic             cal;
	tkbd_pkg::entry_t e2;

	// stage 3: baseline and divide by ten
	logic             v_s3;
	tkbd_pkg::item_t  it_s3;
	logic [KW-1:0]    idx_s3;
	logic             ok_s3;
	logic             meas_s3;
	logic             upd_s3;
	logic             cal_s3;
	tkbd_pkg::entry_t e_s3;
	logic [31:0]      q32;
	logic [15:0]      q;
	tkbd_pkg::entry_t e3;
	logic [32:0]      prod;

	// stage 4: thresholds, hysteresis, write back
	logic             v_s4;
	tkbd_pkg::item_t  it_s4;
	logic [KW-1:0]    idx_s4;
	logic             ok_s4;
	logic             meas_s4;
	logic             upd_s4;
	logic             cal_s4;
	tkbd_pkg::entry_t e_s4;
	logic [32:0]      prod_s4;
	logic [15:0]      low_n;
	logic [15:0]      cnt_c;
	logic [15:0]      diff;

	assign in_idx = KW'(item.key);
	assign in_ok  = ({1'b0, item.key} < cfg.key_count) && (32'(item.key) < 32'(KEYS));

	// hold a request whose key is still in flight, and a clear until the pipe drains
	always_comb begin
		stat.hold = (v_s1 && idx_s1 == in_idx) || (v_s2 && idx_s2 == in_idx) ||
		            (v_s3 && idx_s3 == in_idx) || (v_s4 && idx_s4 == in_idx) ||
		            (item.opcode == tkbd_pkg::OP_CLR && (v_s1 || v_s2 || v_s3 || v_s4));
		stat.inflight = {2'b00, v_s1} + {2'b00, v_s2} + {2'b00, v_s3} + {2'b00, v_s4};
	end

	tkbd_ram #(
		.WIDTH(EW),
		.DEPTH(KEYS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_s4),
		.wdata(e_new),
		.raddr(in_idx),
		.rdata(rd_data)
	);

	assign rd_e = rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			ent_q <= '0;
			cal_q <= '0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (acc && item.opcode == tkbd_pkg::OP_CLR) begin
				cal_q <= '0;
			end
			if (wr_en) begin
				ent_q[idx_s4] <= 1'b1;
				cal_q[idx_s4] <= 1'b1;
			end
		end
	end

	// stage 1: entries never written read as zero; a clear zeroes calibration fields
	always_comb begin
		e1 = rd_e;
		if (!ent_q[idx_s1]) begin
			e1 = '0;
		end
		if (!cal_q[idx_s1]) begin
			e1.cal_max      = '0;
			e1.last_change  = '0;
			e1.strobe_start = '0;
		end
		dt_dbn = it_s1.now_ms - e1.last_change;
		dt_str = it_s1.now_ms - e1.strobe_start;
		thr    = {1'b0, e1.mean} + {2'b00, e1.low[15:1]};
		calmax = (it_s1.raw_count > e1.cal_max) ? it_s1.raw_count : e1.cal_max;
	end

	// stage 2
	always_comb begin
		frozen = dt_dbn_s2 <= 32'(cfg.debounce_ms);
		str_ok = dt_str_s2 > 32'(cfg.strobe_ms);
		upd    = {1'b0, it_s2.raw_count} <= thr_s2;
		meas   = ok_s2 && it_s2.opcode == tkbd_pkg::OP_MEAS && !frozen;
		cal    = ok_s2 && it_s2.opcode == tkbd_pkg::OP_CAL;
		e2     = e_s2;
		if (cal) begin
			e2.cal_max       = calmax_s2;
			e2.mean          = calmax_s2;
			e2.running_total = 32'(calmax_s2) << tkbd_pkg::AVG_LOG2;
		end else if (meas && upd && str_ok) begin
			e2.running_total = e_s2.running_total - 32'(e_s2.mean) + 32'(it_s2.raw_count);
		end
	end

	// stage 3: saturate the baseline and start the divide by ten
	always_comb begin
		q32 = e_s3.running_total >> tkbd_pkg::AVG_LOG2;
		q   = (|q32[31:16]) ? 16'hFFFF : q32[15:0];
		e3  = e_s3;
		if (meas_s3 && upd_s3) begin
			e3.mean = q;
		end
		prod = 33'(q) * 33'(tkbd_pkg::DIV10_MUL);
	end

	// stage 4
	always_comb begin
		e_new = e_s4;
		low_n = 16'(prod_s4 >> tkbd_pkg::DIV10_SHIFT);
		if (meas_s4 && upd_s4) begin
			e_new.low  = low_n;
			e_new.high = low_n + {2'b00, low_n[15:2]};
		end
		cnt_c = (it_s4.raw_count < e_new.mean) ? e_new.mean : it_s4.raw_count;
		diff  = cnt_c - e_new.mean;
		if (meas_s4) begin
			e_new.changed = 1'b0;
			if (diff > e_new.high) begin
				if (!e_s4.pressed) begin
					e_new.changed      = 1'b1;
					e_new.last_change  = it_s4.now_ms;
					e_new.strobe_start = it_s4.now_ms;
				end
				e_new.pressed = 1'b1;
			end else if (diff < e_new.low) begin
				if (e_s4.pressed) begin
					e_new.changed      = 1'b1;
					e_new.last_change  = it_s4.now_ms;
					e_new.strobe_start = it_s4.now_ms;
				end
				e_new.pressed = 1'b0;
			end
		end
		wr_en = v_s4 && (meas_s4 || cal_s4);

		res.key_out  = it_s4.key;
		res.ignored  = !ok_s4;
		res.pressed  = ok_s4 && e_new.pressed;
		res.changed  = ok_s4 && e_new.changed;
		res.baseline = ok_s4 ? e_new.mean : 16'd0;
	end

	assign res_valid = v_s4;

	always_ff @(posedge clk) begin
		it_s1     <= item;
		idx_s1    <= in_idx;
		ok_s1     <= in_ok;

		it_s2     <= it_s1;
		idx_s2    <= idx_s1;
		ok_s2     <= ok_s1;
		e_s2      <= e1;
		dt_dbn_s2 <= dt_dbn;
		dt_str_s2 <= dt_str;
		thr_s2    <= thr;
		calmax_s2 <= calmax;

		it_s3     <= it_s2;
		idx_s3    <= idx_s2;
		ok_s3     <= ok_s2;
		meas_s3   <= meas;
		upd_s3    <= upd;
		cal_s3    <= cal;
		e_s3      <= e2;

		it_s4     <= it_s3;
		idx_s4    <= idx_s3;
		ok_s4     <= ok_s3;
		meas_s4   <= meas_s3;
		upd_s4    <= upd_s3;
		cal_s4    <= cal_s3;
		e_s4      <= e3;
		prod_s4   <= prod;
	end

	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2) |-> (idx_s1 != idx_s2 && idx_s1 != idx_s3 || !v_s3))
		else $error("two in-flight requests share a key");

	a_clr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item.opcode == tkbd_pkg::OP_CLR) |-> !(v_s1 || v_s2 || v_s3 || v_s4))
		else $error("clear taken with requests in flight");

	a_wr_marks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (ent_q[$past(idx_s4)] && cal_q[$past(idx_s4)]))
		else $error("written entry not marked valid");

	a_cal_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && cal_s4) |-> (e_new.mean == e_new.cal_max))
		else $error("calibration did not preload the baseline");

endmodule

[rtl/tkbd_ofifo.sv]
// Result queue between the pipeline and the output channel.
// Depends on tkbd_pkg.
module tkbd_ofifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  tkbd_pkg::result_t              push_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tkbd_pkg::result_t              out_data,
	output logic [tkbd_pkg::OFIFO_CW-1:0]  count
);

	tkbd_pkg::result_t               buf_q [tkbd_pkg::OFIFO_DEPTH];
	logic [tkbd_pkg::OFIFO_PW-1:0]   wr_ptr_q;
	logic [tkbd_pkg::OFIFO_PW-1:0]   rd_ptr_q;
	logic [tkbd_pkg::OFIFO_CW-1:0]   cnt_q;
	logic                            pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign out_data  = buf_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < tkbd_pkg::OFIFO_CW'(tkbd_pkg::OFIFO_DEPTH) || pop))
		else $error("result queue overflow");

endmodule

[rtl/touch_key_baseline_detector_core.sv]
// Touch key baseline detector. Throughput one request per cycle while the key asked for
// is not in flight and the result queue has room for it and every request in flight; a
// request for a key still in the four-stage state RAM read-modify-write waits until that
// key is written back, and clear calibration waits until the pipeline has drained.
// Reset (arst_n low) zeroes all per-key state through valid flags, empties the result
// queue and loads key_count 8, debounce_ms 50, strobe_ms 200.
module touch_key_baseline_detector_core #(
	parameter int KEYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [2:0]  key,
	input  logic [15:0] raw_count,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  key_out,
	output logic        pressed,
	output logic        changed,
	output logic [15:0] baseline,
	output logic        ignored,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tkbd_pkg::cfg_t                  cfg_q;
	tkbd_pkg::item_t                 item;
	tkbd_pkg::pipe_stat_t            stat;
	tkbd_pkg::result_t               res;
	tkbd_pkg::result_t               head;
	logic                            res_valid;
	logic                            acc;
	logic [tkbd_pkg::OFIFO_CW-1:0]   fifo_cnt;
	logic [tkbd_pkg::OFIFO_CW:0]     committed;
	logic                            credit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_count   <= 4'd8;
			cfg_q.debounce_ms <= 16'd50;
			cfg_q.strobe_ms   <= 16'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tkbd_pkg::CFG_KEY_COUNT: cfg_q.key_count   <= cfg_data[3:0];
				tkbd_pkg::CFG_DEBOUNCE:  cfg_q.debounce_ms <= cfg_data;
				tkbd_pkg::CFG_STROBE:    cfg_q.strobe_ms   <= cfg_data;
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	assign item.opcode    = opcode;
	assign item.key       = key;
	assign item.raw_count = raw_count;
	assign item.now_ms    = now_ms;

	// reserve a queue slot for every request in flight
	assign committed = {1'b0, fifo_cnt} + (tkbd_pkg::OFIFO_CW + 1)'(stat.inflight);
	assign credit_ok = committed < (tkbd_pkg::OFIFO_CW + 1)'(tkbd_pkg::OFIFO_DEPTH);
	assign in_stall  = stat.hold || !credit_ok;
	assign acc       = in_valid && !in_stall;

	tkbd_pipe #(
		.KEYS(KEYS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.item     (item),
		.cfg      (cfg_q),
		.stat     (stat),
		.res_valid(res_valid),
		.res      (res)
	);

	tkbd_ofifo u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (head),
		.count    (fifo_cnt)
	);

	assign key_out  = head.key_out;
	assign pressed  = head.pressed;
	assign changed  = head.changed;
	assign baseline = head.baseline;
	assign ignored  = head.ignored;

endmodule

[sim/tkbd_report_checker.sv]
`timescale 1ns / 100ps
// Report checker for the touch key baseline detector: keeps its own copy of the per-key
// state and registers, predicts one report per accepted request and compares the output.
// Depends on tkbd_pkg for opcodes, register indexes and the report type.
module tkbd_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [2:0]  key,
	input  logic [15:0] raw_count,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  key_out,
	input  logic        pressed,
	input  logic        changed,
	input  logic [15:0] baseline,
	input  logic        ignored,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          outstanding
);

	localparam int NKEYS = 8;
	localparam logic [31:0] DEPTH = 32'(tkbd_pkg::AVG_DEPTH);

	logic [31:0] trk_total        [NKEYS];
	logic [15:0] trk_mean         [NKEYS];
	logic [15:0] trk_low          [NKEYS];
	logic [15:0] trk_high         [NKEYS];
	logic        trk_pressed      [NKEYS];
	logic        trk_changed      [NKEYS];
	logic [31:0] trk_last_change  [NKEYS];
	logic [31:0] trk_strobe_start [NKEYS];
	logic [15:0] trk_cal_max      [NKEYS];

	logic [3:0]  keys_in_use;
	logic [15:0] debounce_win;
	logic [15:0] strobe_win;

	tkbd_pkg::result_t expected_reports[$];

	function automatic void track_measurement(input logic [2:0] k, input logic [15:0] sample,
			input logic [31:0] now);
		logic [31:0] since_change, since_strobe, ceiling, q, cnt, m, diff;
		since_change = now - trk_last_change[k];
		since_strobe = now - trk_strobe_start[k];
		// frozen while the debounce window is still open
		if (since_change <= {16'd0, debounce_win})
			return;
		cnt = {16'd0, sample};
		m = {16'd0, trk_mean[k]};
		ceiling = {17'd0, trk_low[k][15:1]} + m;
		if (cnt <= ceiling) begin
			if (since_strobe > {16'd0, strobe_win})
				trk_total[k] = trk_total[k] - m + cnt;
			q = trk_total[k] / DEPTH;
			if (q > 32'd65535)
				q = 32'd65535;
			trk_mean[k] = q[15:0];
			trk_low[k] = q[15:0] / 16'd10;
			trk_high[k] = trk_low[k] + (trk_low[k] >> 2);
		end
		m = {16'd0, trk_mean[k]};
		trk_changed[k] = 1'b0;
		if (cnt < m)
			cnt = m;
		diff = cnt - m;
		if (diff > {16'd0, trk_high[k]}) begin
			if (!trk_pressed[k]) begin
				trk_changed[k] = 1'b1;
				trk_last_change[k] = now;
				trk_strobe_start[k] = now;
			end
			trk_pressed[k] = 1'b1;
		end else if (diff < {16'd0, trk_low[k]}) begin
			if (trk_pressed[k]) begin
				trk_changed[k] = 1'b1;
				trk_last_change[k] = now;
				trk_strobe_start[k] = now;
			end
			trk_pressed[k] = 1'b0;
		end
	endfunction

	function automatic tkbd_pkg::result_t predict_report(input logic [1:0] op,
			input logic [2:0] k, input logic [15:0] sample, input logic [31:0] now);
		tkbd_pkg::result_t r;
		logic in_use;
		int i;
		in_use = (k < keys_in_use);
		if (op == tkbd_pkg::OP_CLR) begin
			// clear applies to every key, even when the named one is out of range
			for (i = 0; i < NKEYS; i++) begin
				trk_cal_max[i] = '0;
				trk_last_change[i] = '0;
				trk_strobe_start[i] = '0;
			end
		end else if (in_use && op == tkbd_pkg::OP_MEAS) begin
			track_measurement(k, sample, now);
		end else if (in_use && op == tkbd_pkg::OP_CAL) begin
			if (sample > trk_cal_max[k])
				trk_cal_max[k] = sample;
			trk_total[k] = {16'd0, trk_cal_max[k]} * DEPTH;
			trk_mean[k] = trk_cal_max[k];
		end
		r.key_out = k;
		r.pressed = in_use ? trk_pressed[k] : 1'b0;
		r.changed = in_use ? trk_changed[k] : 1'b0;
		r.baseline = in_use ? trk_mean[k] : 16'd0;
		r.ignored = !in_use;
		return r;
	endfunction

	task automatic flag_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tkbd_pkg::result_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < NKEYS; i++) begin
				trk_total[i] = '0;
				trk_mean[i] = '0;
				trk_low[i] = '0;
				trk_high[i] = '0;
				trk_pressed[i] = 1'b0;
				trk_changed[i] = 1'b0;
				trk_last_change[i] = '0;
				trk_strobe_start[i] = '0;
				trk_cal_max[i] = '0;
			end
			keys_in_use = 4'd8;
			debounce_win = 16'd50;
			strobe_win = 16'd200;
			expected_reports.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tkbd_pkg::CFG_KEY_COUNT: keys_in_use = cfg_data[3:0];
					tkbd_pkg::CFG_DEBOUNCE:  debounce_win = cfg_data;
					tkbd_pkg::CFG_STROBE:    strobe_win = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(predict_report(opcode, key, raw_count, now_ms));
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none, got key %0d", $time,
						key_out);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					if (key_out !== want.key_out)
						flag_field("key_out", 32'(want.key_out), 32'(key_out));
					if (pressed !== want.pressed)
						flag_field("pressed", 32'(want.pressed), 32'(pressed));
					if (changed !== want.changed)
						flag_field("changed", 32'(want.changed), 32'(changed));
					if (baseline !== want.baseline)
						flag_field("baseline", 32'(want.baseline), 32'(baseline));
					if (ignored !== want.ignored)
						flag_field("ignored", 32'(want.ignored), 32'(ignored));
				end
			end
			outstanding <= expected_reports.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for touch_key_baseline_detector_core: clock, reset, register writes,
// bursty request stimulus, output stall pattern and the verdict.
// Depends on tkbd_pkg and on tkbd_report_checker, which predicts and compares reports.
module tb_top;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = tkbd_pkg::OP_NOP;
	logic [2:0]  key = '0;
	logic [15:0] raw_count = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  key_out;
	logic        pressed;
	logic        changed;
	logic [15:0] baseline;
	logic        ignored;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = tkbd_pkg::CFG_KEY_COUNT;
	logic [15:0] cfg_data = '0;

	int errors;
	int outstanding;

	logic [8:0]  stall_cycle = '0;
	logic [31:0] clock_ms = '0;
	int          nominal [8];
	bit          touching [8];
	int          kc_now = 8;
	int          deb_now = 50;
	int          burst_left = 0;

	touch_key_baseline_detector_core dut (.*);

	tkbd_report_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// receiver: free-running, then light, heavy and periodic stalls
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 9'd1;
		case (stall_cycle[8:7])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_cycle[3:0] < 4'd6);
		endcase
	end

	task automatic send_req(input logic [1:0] op, input logic [2:0] k,
			input logic [15:0] cnt, input logic [31:0] ts);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		opcode <= op;
		key <= k;
		raw_count <= cnt;
		now_ms <= ts;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic retune(input int kc, input int deb, input int str);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= tkbd_pkg::CFG_KEY_COUNT;
		cfg_data <= 16'(kc);
		@(posedge clk);
		cfg_index <= tkbd_pkg::CFG_DEBOUNCE;
		cfg_data <= 16'(deb);
		@(posedge clk);
		cfg_index <= tkbd_pkg::CFG_STROBE;
		cfg_data <= 16'(str);
		@(posedge clk);
		cfg_we <= 1'b0;
		kc_now = kc;
		deb_now = deb;
	endtask

	function automatic void advance_time(input bit long_windows);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			clock_ms = $urandom();
		else if (roll == 99)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
		else if (roll < (long_windows ? 14 : 4))
			clock_ms += $urandom_range(60000, 90000);
		else if (roll < 22)
			clock_ms += $urandom_range(60, 600);
		else
			clock_ms += $urandom_range(0, 60);
	endfunction

	function automatic int pick_nominal();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return $urandom_range(58000, 65535);
		if (roll == 1)
			return $urandom_range(0, 40);
		return $urandom_range(300, 9000);
	endfunction

	function automatic logic [15:0] near_nominal(input int k);
		int c;
		c = nominal[k] + $urandom_range(0, 8);
		if (c > 65535)
			c = 65535;
		return 16'(c);
	endfunction

	// untouched counts sit near the nominal, touched ones well above it
	function automatic logic [15:0] measure_count(input int k);
		int nom, c;
		nom = nominal[k];
		if ($urandom_range(0, 19) == 0)
			return 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 9) == 0)
			touching[k] = !touching[k];
		if (touching[k])
			c = nom + nom / 5 + $urandom_range(0, nom / 4 + 1);
		else
			c = nom - nom / 64 + $urandom_range(0, nom / 32 + 1);
		if (c > 65535)
			c = 65535;
		return 16'(c);
	endfunction

	task automatic run_phase(input int target);
		int done, k, roll, i;
		logic [1:0] op;
		logic [15:0] cnt;
		bit long_win;
		done = 0;
		long_win = (deb_now > 1000);
		for (i = 0; i < 8; i++) begin
			nominal[i] = pick_nominal();
			touching[i] = 1'b0;
		end
		// calibrate every key so tracking has a baseline to work from
		for (i = 0; i < 8; i++) begin
			repeat (2) begin
				advance_time(long_win);
				send_req(tkbd_pkg::OP_CAL, 3'(i), near_nominal(i), clock_ms);
			end
		end
		while (done < target) begin
			roll = $urandom_range(0, 99);
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, kc_now - 1);
			advance_time(long_win);
			if (roll < 80) begin
				op = tkbd_pkg::OP_MEAS;
				cnt = measure_count(k);
			end else if (roll < 90) begin
				op = tkbd_pkg::OP_CAL;
				cnt = near_nominal(k);
			end else if (roll < 93) begin
				op = tkbd_pkg::OP_CLR;
				cnt = 16'($urandom());
			end else if (roll < 96) begin
				op = tkbd_pkg::OP_NOP;
				cnt = 16'($urandom());
			end else begin
				op = tkbd_pkg::OP_MEAS;
				cnt = 16'($urandom_range(0, 65535));
			end
			send_req(op, 3'(k), cnt, clock_ms);
			if (op == tkbd_pkg::OP_CLR || (op != tkbd_pkg::OP_NOP && k < kc_now))
				done++;
			if ($urandom_range(0, 149) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(tkbd_pkg::OP_NOP, 3'd0, 16'd0, 32'd0);
		send_req(tkbd_pkg::OP_MEAS, 3'd0, 16'd0, 32'd0);            // still inside debounce after reset
		send_req(tkbd_pkg::OP_MEAS, 3'd7, 16'hFFFF, 32'hFFFF_FFFF); // far above a zero baseline
		send_req(tkbd_pkg::OP_CAL, 3'd1, 16'd1000, 32'd100);
		send_req(tkbd_pkg::OP_CAL, 3'd1, 16'd900, 32'd110);         // lower sample keeps the max
		send_req(tkbd_pkg::OP_CAL, 3'd1, 16'd1200, 32'd120);
		send_req(tkbd_pkg::OP_MEAS, 3'd1, 16'd1210, 32'd200);
		send_req(tkbd_pkg::OP_MEAS, 3'd1, 16'd1600, 32'd300);       // stays pressed
		send_req(tkbd_pkg::OP_MEAS, 3'd1, 16'd1200, 32'd320);       // release
		send_req(tkbd_pkg::OP_MEAS, 3'd1, 16'd1205, 32'd400);       // stays released, total held by strobe
		send_req(tkbd_pkg::OP_MEAS, 3'd1, 16'd1205, 32'd700);
		send_req(tkbd_pkg::OP_CLR, 3'd3, 16'd0, 32'd800);
		send_req(tkbd_pkg::OP_CAL, 3'd1, 16'd500, 32'd810);
		send_req(tkbd_pkg::OP_MEAS, 3'd2, 16'd0, 32'd1000);
		send_req(tkbd_pkg::OP_MEAS, 3'd7, 16'd0, 32'd70000);
		send_req(tkbd_pkg::OP_NOP, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
		send_req(tkbd_pkg::OP_CAL, 3'd4, 16'hFFFF, 32'd1100);
		send_req(tkbd_pkg::OP_MEAS, 3'd4, 16'hFFFF, 32'd1200);
		clock_ms = 32'd2000;
		run_phase(120);

		retune(8, 0, 0);
		run_phase(120);

		retune(1, 65535, 65535);
		// out-of-range keys: no state change, but clear still hits every key
		send_req(tkbd_pkg::OP_MEAS, 3'd5, 16'd300, clock_ms);
		send_req(tkbd_pkg::OP_CAL, 3'd7, 16'd4000, clock_ms);
		send_req(tkbd_pkg::OP_CLR, 3'd3, 16'd0, clock_ms);
		send_req(tkbd_pkg::OP_NOP, 3'd1, 16'd0, clock_ms);
		run_phase(120);

		retune($urandom_range(2, 7), $urandom_range(1, 300), $urandom_range(0, 1000));
		run_phase(120);

		retune(4, 20, 65535);
		run_phase(120);

		retune(8, 65535, 0);
		run_phase(120);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
